// ----- rtl/fpfa_pkg.sv -----
// Types, codes and defaults shared by the partition fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package fpfa_pkg;

   localparam int PARTITIONS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   localparam int KIND_W   = 1;
   localparam int INDEX_W  = 4;
   localparam int AMOUNT_W = 16;
   localparam int MODE_W   = 2;
   localparam int COUNT_W  = 5;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_FIT_MODE    = 3'd0;
   localparam logic [ADDR_W-1:0] ADDR_BLOCK_COUNT = 3'd4;

   localparam logic [MODE_W-1:0]  FIT_MODE_RST    = FIT_FIRST;
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [INDEX_W-1:0]  load_index;
      logic [AMOUNT_W-1:0] amount;
   } req_item_type;

   typedef struct packed {
      logic                found;
      logic [INDEX_W-1:0]  chosen_index;
      logic [AMOUNT_W-1:0] leftover;
   } rsp_item_type;

endpackage
`default_nettype wire

// ----- rtl/fixed_partition_fit_allocator_top.sv -----
// Partition fit allocator: size memory, used marks, scan sequencer and register port.
// Load item: written at its accept edge, busy stays low, no result.
// Request item: one size read per cycle over L = min(block_count, PARTITIONS) partitions;
// result strobe registered in FINISH (after SCAN, DRAIN; directly if L = 0); busy drops with it.
// Throughput is set by the single read port of the size memory.
// Synchronous reset clears the used marks, the sequencer and the registers; sizes are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module fixed_partition_fit_allocator_top #(
   parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
   parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  fpfa_pkg::req_item_type       req_item,
   output logic                               rsp_valid,
   output fpfa_pkg::rsp_item_type             rsp_item,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [fpfa_pkg::ADDR_W-1:0]        paddr,
   input  wire  [fpfa_pkg::DATA_W-1:0]        pwdata,
   output logic [fpfa_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

   localparam int IDX_BITS = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int IW       = (IDX_BITS > fpfa_pkg::INDEX_W) ? IDX_BITS : fpfa_pkg::INDEX_W;
   localparam int AW       = (SIZE_BITS > fpfa_pkg::AMOUNT_W) ? SIZE_BITS : fpfa_pkg::AMOUNT_W;
   localparam int CNT_BITS = $clog2(PARTITIONS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [fpfa_pkg::MODE_W-1:0]    fit_mode_ff, fit_mode_in;
   logic [fpfa_pkg::COUNT_W-1:0]   block_count_ff, block_count_in;
   logic [fpfa_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [SIZE_BITS-1:0]           amt_ff, amt_in;
   logic [CNT_BITS-1:0]            limit_ff, limit_in;
   logic [IDX_BITS-1:0]            cnt_ff, cnt_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]            rd_idx_ff, rd_idx_in;
   logic [SIZE_BITS-1:0]           rd_data_ff;
   logic                           have_ff, have_in;
   logic [IDX_BITS-1:0]            pick_ff, pick_in;
   logic [SIZE_BITS-1:0]           best_ff, best_in;
   logic [PARTITIONS-1:0]          used_ff, used_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fpfa_pkg::rsp_item_type         rsp_item_ff, rsp_item_in;

   logic [SIZE_BITS-1:0]           size_mem [PARTITIONS];

   logic                           accept;
   logic                           cfg_write;
   logic [AW-1:0]                  amt_wide;
   logic [SIZE_BITS-1:0]           amt_cut;
   logic [IW-1:0]                  load_wide;
   logic                           load_we;
   logic [IDX_BITS-1:0]            load_addr;
   logic [CNT_BITS-1:0]            limit_cut;
   logic                           scan_last;
   logic                           fits;
   logic [SIZE_BITS-1:0]           rest;
   logic                           take;
   logic [IW-1:0]                  pick_wide;
   logic [AW-1:0]                  best_wide;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign amt_wide  = AW'(req_item.amount);
   assign amt_cut   = amt_wide[SIZE_BITS-1:0];
   assign load_wide = IW'(req_item.load_index);
   assign load_addr = load_wide[IDX_BITS-1:0];
   assign load_we   = accept && (req_item.kind == fpfa_pkg::KIND_LOAD)
                      && (32'(req_item.load_index) < 32'(PARTITIONS));
   assign limit_cut = (32'(block_count_ff) > 32'(PARTITIONS)) ? CNT_BITS'(PARTITIONS)
                                                             : CNT_BITS'(block_count_ff);
   assign scan_last = (32'(cnt_ff) + 32'd1 == 32'(limit_ff));

   assign fits = !used_ff[rd_idx_ff] && (rd_data_ff >= amt_ff);
   assign rest = rd_data_ff - amt_ff;
   assign take = rd_valid_ff && fits
                 && (!have_ff
                     || ((mode_ff == fpfa_pkg::FIT_BEST) && (rest < best_ff))
                     || ((mode_ff == fpfa_pkg::FIT_WORST) && (rest > best_ff)));

   assign pick_wide = IW'(pick_ff);
   assign best_wide = AW'(best_ff);

   always_comb begin
      prdata = '0;
      case (paddr)
         fpfa_pkg::ADDR_FIT_MODE:    prdata = fpfa_pkg::DATA_W'(fit_mode_ff);
         fpfa_pkg::ADDR_BLOCK_COUNT: prdata = fpfa_pkg::DATA_W'(block_count_ff);
         default:                    prdata = '0;
      endcase
   end

   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (cfg_write) begin
         case (paddr)
            fpfa_pkg::ADDR_FIT_MODE:    fit_mode_in = pwdata[fpfa_pkg::MODE_W-1:0];
            fpfa_pkg::ADDR_BLOCK_COUNT: block_count_in = pwdata[fpfa_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      amt_in       = amt_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      have_in      = have_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;

      if (take) begin
         have_in = 1'b1;
         pick_in = rd_idx_ff;
         best_in = rest;
      end

      case (state_ff)
         ST_IDLE: begin
            if (load_we) begin
               used_in[load_addr] = 1'b0;
            end
            if (accept && (req_item.kind == fpfa_pkg::KIND_REQUEST)) begin
               mode_in  = fit_mode_ff;
               amt_in   = amt_cut;
               limit_in = limit_cut;
               cnt_in   = '0;
               have_in  = 1'b0;
               pick_in  = '0;
               best_in  = '0;
               state_in = (limit_cut == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            rd_idx_in   = cnt_ff;
            cnt_in      = cnt_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_item_in.found        = have_ff;
            rsp_item_in.chosen_index = have_ff ? pick_wide[fpfa_pkg::INDEX_W-1:0] : '0;
            rsp_item_in.leftover     = have_ff ? best_wide[fpfa_pkg::AMOUNT_W-1:0] : '0;
            if (have_ff) begin
               used_in[pick_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         size_mem[load_addr] <= amt_cut;
      end
      if (state_ff == ST_SCAN) begin
         rd_data_ff <= size_mem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_mode_ff    <= fpfa_pkg::FIT_MODE_RST;
         block_count_ff <= fpfa_pkg::BLOCK_COUNT_RST;
         rd_valid_ff    <= 1'b0;
         have_ff        <= 1'b0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
         rd_valid_ff    <= rd_valid_in;
         have_ff        <= have_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      amt_ff      <= amt_in;
      limit_ff    <= limit_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule
`default_nettype wire

// ----- rtl/fpfa_checker.sv -----
// Port-level assertions for the partition fit allocator and their bind.
`timescale 1ns / 1ps
`default_nettype none
module fpfa_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire fpfa_pkg::req_item_type  req_item,
   input wire                          rsp_valid,
   input wire fpfa_pkg::rsp_item_type  rsp_item
);

   a_req_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.kind == fpfa_pkg::KIND_REQUEST)) |=> busy)
      else $error("request item did not raise busy");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.kind == fpfa_pkg::KIND_LOAD)) |=> !busy)
      else $error("load item raised busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.found) |-> (rsp_item.chosen_index == '0)
                                         && (rsp_item.leftover == '0))
      else $error("miss result carries nonzero fields");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

endmodule

bind fixed_partition_fit_allocator_top fpfa_checker u_fpfa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking bench for the partition fit allocator: loads, fit requests and mode/count settings.
`timescale 1ns / 1ps
module tb;

   localparam logic [fpfa_pkg::MODE_W-1:0] FIT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = fpfa_pkg::PARTITIONS_DEF + 8;

   class partition_fit_scoreboard;
      logic [fpfa_pkg::AMOUNT_W-1:0] part_size [fpfa_pkg::PARTITIONS_DEF];
      bit                            part_used [fpfa_pkg::PARTITIONS_DEF];
      logic [fpfa_pkg::MODE_W-1:0]   fit_mode;
      logic [fpfa_pkg::COUNT_W-1:0]  block_count;
      fpfa_pkg::rsp_item_type        expected_grants [$];
      int                            failures;

      function new();
         fit_mode = fpfa_pkg::FIT_MODE_RST;
         block_count = fpfa_pkg::BLOCK_COUNT_RST;
         failures = 0;
         foreach (part_used[k]) begin
            part_used[k] = 1'b0;
            part_size[k] = '0;
         end
      endfunction

      function void configure(logic [fpfa_pkg::ADDR_W-1:0] addr,
                              logic [fpfa_pkg::DATA_W-1:0] data);
         case (addr)
            fpfa_pkg::ADDR_FIT_MODE: begin
               fit_mode = data[fpfa_pkg::MODE_W-1:0];
            end
            fpfa_pkg::ADDR_BLOCK_COUNT: begin
               block_count = data[fpfa_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction

      function void note_item(fpfa_pkg::req_item_type it);
         fpfa_pkg::rsp_item_type        grant;
         int                            limit;
         logic [fpfa_pkg::AMOUNT_W-1:0] rest;
         bit                            have;
         if (it.kind == fpfa_pkg::KIND_LOAD) begin
            part_size[it.load_index] = it.amount;
            part_used[it.load_index] = 1'b0;
            return;
         end
         have = 1'b0;
         grant = '0;
         limit = (block_count > fpfa_pkg::PARTITIONS_DEF) ? fpfa_pkg::PARTITIONS_DEF
                                                          : int'(block_count);
         for (int k = 0; k < limit; k++) begin
            if (part_used[k] || part_size[k] < it.amount) continue;
            rest = part_size[k] - it.amount;
            if (!have) begin
               have = 1'b1;
               grant.chosen_index = fpfa_pkg::INDEX_W'(k);
               grant.leftover = rest;
               if (fit_mode != fpfa_pkg::FIT_BEST && fit_mode != fpfa_pkg::FIT_WORST) break;
            end else if ((fit_mode == fpfa_pkg::FIT_BEST && rest < grant.leftover) ||
                         (fit_mode == fpfa_pkg::FIT_WORST && rest > grant.leftover)) begin
               grant.chosen_index = fpfa_pkg::INDEX_W'(k);
               grant.leftover = rest;
            end
         end
         if (have) begin
            grant.found = 1'b1;
            part_used[grant.chosen_index] = 1'b1;
         end
         expected_grants.push_back(grant);
      endfunction

      function void check_grant(fpfa_pkg::rsp_item_type got);
         fpfa_pkg::rsp_item_type want;
         if (expected_grants.size() == 0) begin
            $error("unexpected result: found %0d index %0d leftover %0d",
                   got.found, got.chosen_index, got.leftover);
            failures++;
            return;
         end
         want = expected_grants.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
         end
         if (got.chosen_index !== want.chosen_index) begin
            $error("chosen_index: expected %0d, actual %0d", want.chosen_index, got.chosen_index);
            failures++;
         end
         if (got.leftover !== want.leftover) begin
            $error("leftover: expected %0d, actual %0d", want.leftover, got.leftover);
            failures++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   fpfa_pkg::req_item_type        req_item = '0;
   logic                          rsp_valid;
   fpfa_pkg::rsp_item_type        rsp_item;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [fpfa_pkg::ADDR_W-1:0]   paddr = '0;
   logic [fpfa_pkg::DATA_W-1:0]   pwdata = '0;
   logic [fpfa_pkg::DATA_W-1:0]   prdata;
   logic                          pready;

   partition_fit_scoreboard ledger = new();

   fixed_partition_fit_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("** fixed_partition_fit_allocator_top: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         ledger.check_grant(rsp_item);
      end
   end

   function automatic fpfa_pkg::req_item_type make_item(logic [fpfa_pkg::KIND_W-1:0] kind,
                                                        int idx, int amount);
      fpfa_pkg::req_item_type it;
      it.kind = kind;
      it.load_index = fpfa_pkg::INDEX_W'(idx);
      it.amount = fpfa_pkg::AMOUNT_W'(amount);
      return it;
   endfunction

   function automatic logic [fpfa_pkg::AMOUNT_W-1:0] pick_amount();
      logic [fpfa_pkg::AMOUNT_W-1:0] base;
      base = ledger.part_size[$urandom_range(0, fpfa_pkg::PARTITIONS_DEF - 1)];
      case ($urandom_range(0, 4))
         0: return fpfa_pkg::AMOUNT_W'($urandom);
         1: return fpfa_pkg::AMOUNT_W'($urandom_range(0, 15) * 64);
         2: return $urandom_range(0, 1) ? '1 : '0;
         3: return base;
         default: return (base > 3) ? base - fpfa_pkg::AMOUNT_W'($urandom_range(0, 3)) : base;
      endcase
   endfunction

   function automatic fpfa_pkg::req_item_type random_item();
      fpfa_pkg::req_item_type it;
      it.kind = ($urandom_range(0, 99) < 35) ? fpfa_pkg::KIND_LOAD : fpfa_pkg::KIND_REQUEST;
      it.load_index = fpfa_pkg::INDEX_W'($urandom_range(0, fpfa_pkg::PARTITIONS_DEF - 1));
      it.amount = pick_amount();
      return it;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue_item(input fpfa_pkg::req_item_type it, input bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_item(it);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fpfa_pkg::ADDR_W-1:0] addr,
                            input logic [fpfa_pkg::DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      ledger.configure(addr, data);
   endtask

   task automatic run_phase(input logic [fpfa_pkg::MODE_W-1:0] mode, input int count,
                            input int n);
      bit steady;
      drain();
      write_csr(fpfa_pkg::ADDR_FIT_MODE, fpfa_pkg::DATA_W'(mode));
      write_csr(fpfa_pkg::ADDR_BLOCK_COUNT, fpfa_pkg::DATA_W'(count));
      steady = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < n; i++) begin
         issue_item(random_item(), steady);
      end
   endtask

   initial begin
      int sizes [fpfa_pkg::PARTITIONS_DEF];
      sizes = '{0, 65535, 100, 100, 1, 32768, 7, 200, 65534, 100, 4095, 16, 300, 255, 1024, 50};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every partition before any scan, then probe exact and failed fits
      for (int p = 0; p < fpfa_pkg::PARTITIONS_DEF; p++) begin
         issue_item(make_item(fpfa_pkg::KIND_LOAD, p, sizes[p]), p[0]);
      end
      issue_item(make_item(fpfa_pkg::KIND_REQUEST, 0, 0), 1'b0);
      issue_item(make_item(fpfa_pkg::KIND_REQUEST, 15, 65535), 1'b0);
      issue_item(make_item(fpfa_pkg::KIND_REQUEST, 0, 65535), 1'b1);
      issue_item(make_item(fpfa_pkg::KIND_REQUEST, 0, 100), 1'b0);
      issue_item(make_item(fpfa_pkg::KIND_REQUEST, 0, 1), 1'b1);
      issue_item(make_item(fpfa_pkg::KIND_LOAD, 1, 65535), 1'b1);
      issue_item(make_item(fpfa_pkg::KIND_REQUEST, 0, 65535), 1'b0);

      run_phase(fpfa_pkg::FIT_BEST, 16, 80);
      run_phase(fpfa_pkg::FIT_WORST, 16, 80);
      run_phase(FIT_UNUSED, 16, 60);
      run_phase(fpfa_pkg::FIT_FIRST, 0, 40);
      run_phase(fpfa_pkg::FIT_BEST, 1, 60);
      run_phase(fpfa_pkg::FIT_WORST, 31, 80);
      run_phase(fpfa_pkg::FIT_FIRST, 8, 80);
      run_phase(fpfa_pkg::FIT_BEST, 17, 80);
      run_phase(fpfa_pkg::FIT_WORST, 5, 80);
      run_phase(fpfa_pkg::MODE_W'($urandom_range(0, 3)), $urandom_range(0, 31), 90);
      run_phase(fpfa_pkg::MODE_W'($urandom_range(0, 3)), $urandom_range(0, 31), 90);
      run_phase(fpfa_pkg::MODE_W'($urandom_range(0, 3)), $urandom_range(0, 31), 90);

      drain();
      if (ledger.failures == 0) begin
         $display("** fixed_partition_fit_allocator_top: PASSED **");
      end else begin
         $display("** fixed_partition_fit_allocator_top: FAILED **");
      end
      $finish;
   end

endmodule
